// ===== hw/rtl/dtpy_pkg.sv =====
package dtpy_pkg;

    localparam int COORD_W = 24;
    localparam int ANGLE_W = 25;

    localparam logic [63:0] QUARTER_PI_Q62 = 64'h3243F6A8885A308D;
    localparam logic [63:0] INV_PI_Q64     = 64'h517CC1B727220A95;
    localparam logic [31:0] GAIN_Q30       = 32'd1768195363;
    localparam logic [35:0] DEG_PER_RAD_Q26 =
        36'(((64'(INV_PI_Q64 >> 32) * 64'd180) + 64'd32) >> 6);

    typedef struct packed {
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
    } t_in_word;

    typedef struct packed {
        logic [ANGLE_W-1:0] pitch_angle;
        logic [ANGLE_W-1:0] yaw_angle;
    } t_out_word;

    // atan(2^-i), Q62 radians: pi/4 at i=0, else truncated alternating series.
    function automatic logic [63:0] step_angle(input int i);
        logic [63:0] acc;
        logic [63:0] term;
        int          e;
        acc = 64'd0;
        if (i == 0) begin
            acc = QUARTER_PI_Q62;
        end else begin
            for (int k = 0; k < 32; k++) begin
                e = i * (2 * k + 1);
                if (e < 63) begin
                    term = (64'h4000000000000000 >> e) / 64'(2 * k + 1);
                    if (k % 2 == 1) begin
                        acc = acc - term;
                    end else begin
                        acc = acc + term;
                    end
                end
            end
        end
        return acc;
    endfunction

endpackage

// ===== hw/rtl/direction_to_pitch_yaw_core.sv =====
// Channel   | Valid        | Stall        | Word
// ----------+--------------+--------------+-----------------------------
// input     | i_in_valid   | o_in_stall   | i_in_data (dir x, y, z)
// output    | o_out_valid  | i_out_stall  | o_out_data (pitch, yaw)
//
// One word enters per cycle unless the output is held; the path holds
// 2*CORDIC_STAGES + 6 register stages.
// The two CORDIC passes (yaw first, then pitch on the planar magnitude) are
// chained stages, one micro-rotation per register stage.
// Reset clears only the valid bits of the pipeline.
// A stall on valid output freezes the pipeline; input stalls follow it.
module direction_to_pitch_yaw_core #(
    parameter int CORDIC_STAGES = 22
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  dtpy_pkg::t_in_word    i_in_data,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output dtpy_pkg::t_out_word   o_out_data
);

    localparam int N       = CORDIC_STAGES;
    localparam int SC      = 58 - dtpy_pkg::COORD_W;
    localparam int DEPTH   = 2 * N + 6;
    localparam int FB      = 16;
    localparam logic [24:0] DEG_90  = 25'(90 << FB);
    localparam logic [24:0] DEG_180 = 25'(180 << FB);
    localparam logic [24:0] DEG_270 = 25'(270 << FB);
    localparam logic [24:0] DEG_360 = 25'(360 << FB);

    // Control that rides alongside the datapath.
    typedef struct packed {
        logic       vert;   // x and y both zero
        logic       xneg;
        logic       yneg;
        logic       zpos;
    } t_ctl;

    logic adv;
    assign adv = !(o_out_valid && i_out_stall);
    assign o_in_stall = !adv;

    // One valid bit per register stage; the last one marks the output register.
    logic [DEPTH-1:0] r_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else if (adv) begin
            r_v <= {r_v[DEPTH-2:0], i_in_valid};
        end
    end

    // Stage 0: absolute values and scaling; |z| is kept for the gain product.
    t_ctl                 r_c0;
    logic signed [63:0]   r_x0, r_y0;
    logic [23:0]          r_az0;
    logic [23:0] ax, ay, az;
    always_comb begin
        ax = i_in_data.dir_x[23] ? 24'(-i_in_data.dir_x) : i_in_data.dir_x;
        ay = i_in_data.dir_y[23] ? 24'(-i_in_data.dir_y) : i_in_data.dir_y;
        az = i_in_data.dir_z[23] ? 24'(-i_in_data.dir_z) : i_in_data.dir_z;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_x0 <= 64'(ax) << SC;
            r_y0 <= 64'(ay) << SC;
            r_az0 <= az;
            r_c0 <= '{vert: (ax == 0 && ay == 0), xneg: i_in_data.dir_x[23],
                      yneg: i_in_data.dir_y[23],
                      zpos: !i_in_data.dir_z[23] && (az != 0)};
        end
    end

    // Yaw CORDIC chain; the vertical product travels along.
    logic signed [63:0] r_yx [N+1];
    logic signed [63:0] r_yy [N+1];
    logic signed [63:0] r_ya [N+1];
    logic [63:0]        r_yp [N+1];
    t_ctl               r_yc [N+1];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_yx[0] <= r_x0;
            r_yy[0] <= r_y0;
            r_ya[0] <= '0;
            r_yp[0] <= (64'(r_az0) * 64'(dtpy_pkg::GAIN_Q30)) << (SC - 30);
            r_yc[0] <= r_c0;
        end
    end
    for (genvar i = 0; i < N; i++) begin : g_yaw
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (!r_yy[i][63]) begin
                    r_yx[i+1] <= r_yx[i] + (r_yy[i] >>> i);
                    r_yy[i+1] <= r_yy[i] - (r_yx[i] >>> i);
                    r_ya[i+1] <= r_ya[i] + signed'(dtpy_pkg::step_angle(i));
                end else begin
                    r_yx[i+1] <= r_yx[i] - (r_yy[i] >>> i);
                    r_yy[i+1] <= r_yy[i] + (r_yx[i] >>> i);
                    r_ya[i+1] <= r_ya[i] - signed'(dtpy_pkg::step_angle(i));
                end
                r_yp[i+1] <= r_yp[i];
                r_yc[i+1] <= r_yc[i];
            end
        end
    end

    // Pitch CORDIC chain; the yaw angle travels along.
    logic signed [63:0] r_px [N+1];
    logic signed [63:0] r_py [N+1];
    logic signed [63:0] r_pa [N+1];
    logic signed [63:0] r_th [N+1];
    t_ctl               r_pc [N+1];
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_px[0] <= r_yx[N][63] ? 64'sd0 : r_yx[N];
            r_py[0] <= signed'(r_yp[N]);
            r_pa[0] <= '0;
            r_th[0] <= r_ya[N];
            r_pc[0] <= r_yc[N];
        end
    end
    for (genvar i = 0; i < N; i++) begin : g_pitch
        always_ff @(posedge i_clk) begin
            if (adv) begin
                if (!r_py[i][63]) begin
                    r_px[i+1] <= r_px[i] + (r_py[i] >>> i);
                    r_py[i+1] <= r_py[i] - (r_px[i] >>> i);
                    r_pa[i+1] <= r_pa[i] + signed'(dtpy_pkg::step_angle(i));
                end else begin
                    r_px[i+1] <= r_px[i] - (r_py[i] >>> i);
                    r_py[i+1] <= r_py[i] + (r_px[i] >>> i);
                    r_pa[i+1] <= r_pa[i] - signed'(dtpy_pkg::step_angle(i));
                end
                r_th[i+1] <= r_th[i];
                r_pc[i+1] <= r_pc[i];
            end
        end
    end

    // Conversion to degrees: multiply, then round and clamp, then quadrants.
    logic [32:0] tt, tp;
    always_comb begin
        tt = r_th[N][63] ? 33'd0 : r_th[N][63:31];
        tp = r_pa[N][63] ? 33'd0 : r_pa[N][63:31];
    end
    logic [68:0] r_mt, r_mp;
    t_ctl        r_c1;
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mt <= 69'(tt) * 69'(dtpy_pkg::DEG_PER_RAD_Q26);
            r_mp <= 69'(tp) * 69'(dtpy_pkg::DEG_PER_RAD_Q26);
            r_c1 <= r_pc[N];
        end
    end
    logic [68:0] rt, rp;
    logic [24:0] r_dt, r_dp;
    t_ctl        r_c2;
    always_comb begin
        rt = (r_mt + (69'd1 << (56 - FB))) >> (57 - FB);
        rp = (r_mp + (69'd1 << (56 - FB))) >> (57 - FB);
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_dt <= (rt > 69'(DEG_90)) ? DEG_90 : rt[24:0];
            r_dp <= (rp > 69'(DEG_90)) ? DEG_90 : rp[24:0];
            r_c2 <= r_c1;
        end
    end
    logic [24:0] h, hw, vt;
    always_comb begin
        if (!r_c2.xneg) begin
            h = r_c2.yneg ? DEG_360 - r_dt : r_dt;
        end else begin
            h = r_c2.yneg ? DEG_180 + r_dt : DEG_180 - r_dt;
        end
        hw = (h >= DEG_360) ? h - DEG_360 : h;
        if (r_c2.zpos) begin
            vt = (r_dp == 25'd0) ? 25'd0 : DEG_360 - r_dp;
        end else begin
            vt = r_dp;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            if (r_c2.vert) begin
                o_out_data.yaw_angle   <= '0;
                o_out_data.pitch_angle <= r_c2.zpos ? DEG_270 : DEG_90;
            end else begin
                o_out_data.yaw_angle   <= hw;
                o_out_data.pitch_angle <= vt;
            end
        end
    end
    assign o_out_valid = r_v[DEPTH-1];

    // A held result must not change while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("result changed under stall");
    // Angles stay below a full turn.
    a_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> o_out_data.yaw_angle < DEG_360 &&
                        o_out_data.pitch_angle < DEG_360)
        else $error("angle out of range");
    // The input side stalls only when the output is held.
    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("spurious input stall");

endmodule

// ===== dv/tb_direction_to_pitch_yaw_core.sv =====
`timescale 1ns / 100ps

module tb_direction_to_pitch_yaw_core;

    localparam int COORD_W = dtpy_pkg::COORD_W;
    localparam int ANGLE_W = dtpy_pkg::ANGLE_W;

    // Every accepted direction word yields exactly one angle word after passing
    // 2*22 + 6 register stages.
    localparam int PIPE_LATENCY = 2 * 22 + 6;
    localparam int N_STAGES     = 22;
    localparam int N_RANDOM     = 1300;
    localparam int IDLE_LIMIT   = 5000;

    // Degrees in units of 2^-16, as they appear on the output.
    localparam logic [63:0] DEG_90_FX  = 64'd90 << 16;
    localparam logic [63:0] DEG_180_FX = 64'd180 << 16;
    localparam logic [63:0] DEG_270_FX = 64'd270 << 16;
    localparam logic [63:0] DEG_360_FX = 64'd360 << 16;

    // 180/pi in Q26, derived from the top 32 bits of 1/pi in Q64.
    localparam logic [63:0] RAD2DEG_Q26 = ((64'h517CC1B7 * 64'd180) + 64'd32) >> 6;
    localparam logic [63:0] K_GAIN_Q30  = 64'd1768195363;
    localparam logic [63:0] PI_4_Q62    = 64'h3243F6A8885A308D;

    typedef struct {
        dtpy_pkg::t_in_word  word;
        bit                  fixed;      // expected angles typed in by hand
        dtpy_pkg::t_out_word angles;
    } t_row;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    logic                o_in_stall;
    dtpy_pkg::t_in_word  i_in_data;
    logic                o_out_valid;
    logic                i_out_stall;
    dtpy_pkg::t_out_word o_out_data;

    dtpy_pkg::t_out_word pending_angles[$];
    t_row      directed_rows[$];
    int        n_errors;
    int        idle_cycles;
    int        cycle_count;

    direction_to_pitch_yaw_core #(
        .CORDIC_STAGES(N_STAGES)
    ) uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    // ------------------------------------------------------------------
    // Angle predictor
    // ------------------------------------------------------------------

    // atan(2^-i) in Q62 radians: pi/4 for the first step, and a truncated
    // alternating Taylor series for every later one.
    function automatic longint signed micro_angle(input int i);
        logic [63:0] sum;
        logic [63:0] term;
        int          k;
        sum = 64'd0;
        if (i == 0) begin
            return longint'(PI_4_Q62);
        end
        k = 0;
        while (i * (2 * k + 1) < 63) begin
            term = (64'h4000000000000000 >> (i * (2 * k + 1))) / 64'(2 * k + 1);
            if (k % 2 == 1) begin
                sum = sum - term;
            end else begin
                sum = sum + term;
            end
            k++;
        end
        return longint'(sum);
    endfunction

    // Vectoring rotations drive y to zero; the sum of the applied step angles is
    // the angle of the starting point, and x ends up as the gain-scaled length.
    function automatic longint signed rotate_to_axis(input longint signed x0,
                                                     input longint signed y0,
                                                     output longint signed len);
        longint signed x;
        longint signed y;
        longint signed dx;
        longint signed dy;
        longint signed sum;
        x   = x0;
        y   = y0;
        sum = 0;
        for (int i = 0; i < N_STAGES; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (y >= 0) begin
                x   = x + dx;
                y   = y - dy;
                sum = sum + micro_angle(i);
            end else begin
                x   = x - dx;
                y   = y + dy;
                sum = sum - micro_angle(i);
            end
        end
        len = x;
        return sum;
    endfunction

    // Q62 radians to degrees with 16 fraction bits, rounded half up and held
    // inside the first quadrant.
    function automatic logic [63:0] to_fixed_degrees(input longint signed rad);
        logic [63:0] t;
        logic [63:0] deg;
        if (rad < 0) begin
            rad = 0;
        end
        t   = 64'(rad) >> 31;
        deg = (t * RAD2DEG_Q26 + (64'd1 << 40)) >> 41;
        if (deg > DEG_90_FX) begin
            deg = DEG_90_FX;
        end
        return deg;
    endfunction

    function automatic logic [63:0] wrap_full_turn(input logic [63:0] a);
        return (a >= DEG_360_FX) ? a - DEG_360_FX : a;
    endfunction

    function automatic dtpy_pkg::t_out_word pitch_yaw_of(input dtpy_pkg::t_in_word w);
        dtpy_pkg::t_out_word r;
        longint signed x;
        longint signed y;
        longint signed z;
        longint signed ax;
        longint signed ay;
        longint signed az;
        longint signed plane_len;
        longint signed unused_len;
        logic [63:0]   yaw_q;
        logic [63:0]   pitch_q;
        logic [63:0]   theta;
        logic [63:0]   phi;
        logic [63:0]   vert;
        x  = longint'(w.dir_x);
        y  = longint'(w.dir_y);
        z  = longint'(w.dir_z);
        ax = (x < 0) ? -x : x;
        ay = (y < 0) ? -y : y;
        az = (z < 0) ? -z : z;

        // Straight up or down: no heading can be derived from the plane.
        if (ax == 0 && ay == 0) begin
            r.pitch_angle = (z > 0) ? ANGLE_W'(DEG_270_FX) : ANGLE_W'(DEG_90_FX);
            r.yaw_angle   = '0;
            return r;
        end

        // Heading: first-quadrant angle of |x|,|y|, then unfolded by the signs.
        theta = to_fixed_degrees(rotate_to_axis(ax <<< 34, ay <<< 34, plane_len));
        if (x >= 0) begin
            yaw_q = (y >= 0) ? theta : DEG_360_FX - theta;
        end else begin
            yaw_q = (y >= 0) ? DEG_180_FX - theta : DEG_180_FX + theta;
        end
        yaw_q = wrap_full_turn(yaw_q);

        // Elevation: |z| carries the same CORDIC gain as the plane length.
        vert = (64'(az) * K_GAIN_Q30) << 4;
        if (plane_len < 0) begin
            plane_len = 0;
        end
        phi     = to_fixed_degrees(rotate_to_axis(plane_len, longint'(vert), unused_len));
        pitch_q = (z > 0) ? wrap_full_turn(DEG_360_FX - phi) : phi;

        r.pitch_angle = ANGLE_W'(pitch_q);
        r.yaw_angle   = ANGLE_W'(yaw_q);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Helpers
    // ------------------------------------------------------------------

    task automatic report(input string what, input logic [31:0] got,
                          input logic [31:0] want);
        $display("ERROR @%0t: %s got %0d want %0d", $realtime, what, got, want);
        n_errors++;
    endtask

    task automatic add_row(input int x, input int y, input int z, input bit fixed,
                           input int pitch, input int yaw);
        t_row r;
        r.word.dir_x        = COORD_W'(x);
        r.word.dir_y        = COORD_W'(y);
        r.word.dir_z        = COORD_W'(z);
        r.fixed             = fixed;
        r.angles.pitch_angle = ANGLE_W'(pitch);
        r.angles.yaw_angle   = ANGLE_W'(yaw);
        directed_rows.push_back(r);
    endtask

    function automatic int pick_coord();
        int mode;
        mode = $urandom_range(0, 9);
        if (mode < 6) begin
            return int'($urandom);        // full 24-bit range after truncation
        end else if (mode < 8) begin
            return int'($urandom_range(0, 256)) - 128;
        end else if (mode == 8) begin
            return 0;
        end else begin
            case ($urandom_range(0, 3))
                0:       return 8388607;
                1:       return -8388608;
                2:       return 1;
                default: return -1;
            endcase
        end
    endfunction

    // Idle lengths for either side: mostly none or short, now and then long.
    function automatic int gap_length();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end else if (roll < 95) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 60);
    endfunction

    // Sends one direction word and records its expected angles on acceptance.
    task automatic send_word(input dtpy_pkg::t_in_word w, input bit fixed,
                             input dtpy_pkg::t_out_word want);
        int gap;
        gap = gap_length();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= w;
        forever begin
            @(posedge i_clk);
            if (!o_in_stall) begin
                break;
            end
        end
        pending_angles.push_back(fixed ? want : pitch_yaw_of(w));
        @(negedge i_clk);
    endtask

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------

    initial begin
        dtpy_pkg::t_in_word  w;
        dtpy_pkg::t_out_word none;
        n_errors   = 0;
        none       = '0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_data  = '0;

        // Vertical vectors, including the zero vector, have fixed answers.
        add_row(0, 0, 0, 1, 90 << 16, 0);
        add_row(0, 0, 5, 1, 270 << 16, 0);
        add_row(0, 0, -5, 1, 90 << 16, 0);
        add_row(0, 0, 8388607, 1, 270 << 16, 0);
        add_row(0, 0, -8388608, 1, 90 << 16, 0);
        // Axes, the negative x axis among them, and coordinate extremes.
        add_row(1, 0, 0, 0, 0, 0);
        add_row(-1, 0, 0, 0, 0, 0);
        add_row(-8388608, 0, 0, 0, 0, 0);
        add_row(0, 8388607, 0, 0, 0, 0);
        add_row(0, -8388608, 0, 0, 0, 0);
        add_row(8388607, 8388607, 8388607, 0, 0, 0);
        add_row(-8388608, -8388608, -8388608, 0, 0, 0);
        add_row(8388607, -8388608, 1, 0, 0, 0);
        add_row(-8388608, 8388607, -1, 0, 0, 0);
        // Headings just below a full turn; the first must wrap to zero.
        add_row(8388607, -1, 0, 0, 0, 0);
        add_row(1000, -1, 3, 0, 0, 0);
        // Pitch just below a full turn: tiny positive z under a long plane vector.
        add_row(8388607, 0, 1, 0, 0, 0);
        // Steep elevations and the diagonals of all four quadrants.
        add_row(1, 1, -8388608, 0, 0, 0);
        add_row(1, -1, 8388607, 0, 0, 0);
        add_row(-3, 4, 5, 0, 0, 0);
        add_row(-3, -4, -5, 0, 0, 0);

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[i]) begin
            send_word(directed_rows[i].word, directed_rows[i].fixed,
                      directed_rows[i].angles);
        end

        for (int n = 0; n < N_RANDOM; n++) begin
            w.dir_x = COORD_W'(pick_coord());
            w.dir_y = COORD_W'(pick_coord());
            w.dir_z = COORD_W'(pick_coord());
            send_word(w, 1'b0, none);
        end
        i_in_valid <= 1'b0;

        while (pending_angles.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (PIPE_LATENCY + 10) @(posedge i_clk);

        if (n_errors == 0) begin
            $display("direction_to_pitch_yaw_core: match");
        end else begin
            $display("direction_to_pitch_yaw_core: mismatch");
        end
        $finish;
    end

    // ------------------------------------------------------------------
    // Receiver: random stalls, calm stretches, and two long hold-offs while
    // the sender keeps offering words so the pipeline fills and backs up.
    // ------------------------------------------------------------------

    initial begin
        int stall_left;
        int hold_left;
        stall_left  = 0;
        hold_left   = 0;
        cycle_count = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            cycle_count++;
            if (cycle_count == 1500 || cycle_count == 6000) begin
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                i_out_stall <= 1'b1;
            end else if ((cycle_count / 700) % 3 == 2) begin
                // A calm stretch: the output is ready unless a hold-off or stall runs.
                i_out_stall <= 1'b0;
            end else begin
                stall_left = gap_length();
                i_out_stall <= (stall_left > 0);
                if (stall_left > 0) begin
                    stall_left--;
                end
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker and watchdog
    // ------------------------------------------------------------------

    always @(posedge i_clk) begin
        dtpy_pkg::t_out_word want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_angles.size() == 0) begin
                report("unexpected word, pitch", 32'(o_out_data.pitch_angle), 32'd0);
            end else begin
                want = pending_angles.pop_front();
                if (o_out_data.pitch_angle !== want.pitch_angle) begin
                    report("pitch_angle", 32'(o_out_data.pitch_angle),
                           32'(want.pitch_angle));
                end
                if (o_out_data.yaw_angle !== want.yaw_angle) begin
                    report("yaw_angle", 32'(o_out_data.yaw_angle), 32'(want.yaw_angle));
                end
            end
        end
    end

    // Counts cycles in which neither channel moves a word.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("direction_to_pitch_yaw_core: mismatch");
                $finish;
            end
        end
    end

endmodule
